/* rtl/core/ksa_pkg.sv */
// Package for the k-mer signal accumulator: widths, codes, item and result types.
// Used by every module under rtl/core; depends on nothing.
package ksa_pkg;

  // Window and table geometry
  localparam int KmerLen    = 10;
  localparam int IdxW       = 2 * KmerLen;
  localparam int TableDepth = 1 << IdxW;
  localparam int RunW       = $clog2(KmerLen + 1);

  // Field widths
  localparam int SigW = 16;
  localparam int SumW = 40;
  localparam int CntW = 17;

  localparam logic [CntW-1:0] MaxCountReset = 17'd100000;

  // Item mode codes
  localparam logic ModeAccum  = 1'b0;
  localparam logic ModeLookup = 1'b1;

  // ASCII base characters
  localparam logic [7:0] CharUpA = 8'h41;
  localparam logic [7:0] CharUpC = 8'h43;
  localparam logic [7:0] CharUpG = 8'h47;
  localparam logic [7:0] CharUpT = 8'h54;
  localparam logic [7:0] CharLoA = 8'h61;
  localparam logic [7:0] CharLoC = 8'h63;
  localparam logic [7:0] CharLoG = 8'h67;
  localparam logic [7:0] CharLoT = 8'h74;

  // Base codes; complement is code xor 1
  typedef enum logic [1:0] {
    BASE_A = 2'd0,
    BASE_T = 2'd1,
    BASE_C = 2'd2,
    BASE_G = 2'd3
  } base_e;

  typedef struct packed {
    logic  valid;
    base_e code;
  } base_dec_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic            ready;
    logic            mode;
    logic            fwd_present;
    logic [SigW-1:0] fwd_signal;
    logic            rev_present;
    logic [SigW-1:0] rev_signal;
    logic [IdxW-1:0] fwd_index;
    logic [IdxW-1:0] rev_index;
  } ksa_item_t;

  // One table entry
  typedef struct packed {
    logic [SumW-1:0] sum;
    logic [CntW-1:0] count;
  } ksa_entry_t;

  // Table port request
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    ksa_entry_t      wdata;
    logic [IdxW-1:0] raddr;
  } ksa_mem_req_t;

  // Result item
  typedef struct packed {
    logic            kmer_ready;
    logic [IdxW-1:0] fwd_index;
    logic [IdxW-1:0] rev_index;
    logic            fwd_saturated;
    logic            rev_saturated;
    ksa_entry_t      fwd;
    ksa_entry_t      rev;
  } ksa_result_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_FWD,
    BK_REV
  } bk_state_e;

  // Decode one ASCII byte into a base code
  function automatic base_dec_t decode_base(logic [7:0] c);
    base_dec_t d;
    d.valid = 1'b1;
    d.code  = BASE_A;
    unique case (c) inside
      CharUpA, CharLoA: d.code = BASE_A;
      CharUpT, CharLoT: d.code = BASE_T;
      CharUpC, CharLoC: d.code = BASE_C;
      CharUpG, CharLoG: d.code = BASE_G;
      default:          d.valid = 1'b0;
    endcase
    return d;
  endfunction

endpackage

/* rtl/core/ksa_table.sv */
// Sum and count table: one write and one read port, registered read with
// write bypass for a same-cycle address match. Depends on ksa_pkg.
module ksa_table import ksa_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  ksa_mem_req_t req_i,
  output ksa_entry_t   rdata_o
);

  ksa_entry_t mem_q [TableDepth];
  ksa_entry_t rd_q;
  ksa_entry_t byp_q;
  logic       hit_q;

  // Write and read the array
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rd_q  <= mem_q[req_i.raddr];
    byp_q <= req_i.wdata;
  end

  // Flag a read that collides with the write in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= req_i.we && (req_i.waddr == req_i.raddr);
    end
  end

  assign rdata_o = hit_q ? byp_q : rd_q;

endmodule

/* rtl/core/ksa_front.sv */
// Front end: decode bases, roll the forward and reverse-complement windows,
// classify each item and hold it in a two-entry queue. Depends on ksa_pkg.
module ksa_front import ksa_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            mode_i,
  input  logic [7:0]      base_char_i,
  input  logic            fwd_present_i,
  input  logic [SigW-1:0] fwd_signal_i,
  input  logic            rev_present_i,
  input  logic [SigW-1:0] rev_signal_i,
  input  logic            clear_busy_i,
  output logic            q_valid_o,
  output ksa_item_t       q_item_o,
  input  logic            q_pop_i
);

  logic [IdxW-1:0] fwd_win_q, fwd_win_d;
  logic [IdxW-1:0] rev_win_q, rev_win_d;
  logic [RunW-1:0] run_q, run_d;
  base_dec_t       dec;
  ksa_item_t       item;
  logic            accept;

  ksa_item_t       q_mem_q [2];
  logic            q_wptr_q, q_rptr_q;
  logic [1:0]      q_cnt_q;

  assign in_ready_o = !clear_busy_i && (q_cnt_q != 2'd2);
  assign accept     = in_valid_i && in_ready_o;
  assign dec        = decode_base(base_char_i);

  // Roll the windows and the run counter
  always_comb begin
    fwd_win_d = fwd_win_q;
    rev_win_d = rev_win_q;
    run_d     = run_q;
    if (!dec.valid) begin
      run_d = '0;
    end else begin
      fwd_win_d = {fwd_win_q[IdxW-3:0], dec.code};
      rev_win_d = {dec.code ^ 2'b01, rev_win_q[IdxW-1:2]};
      if (run_q < RunW'(KmerLen)) begin
        run_d = run_q + RunW'(1);
      end
    end
  end

  // Classify the item
  always_comb begin
    item.ready       = dec.valid && (run_q >= RunW'(KmerLen - 1));
    item.mode        = mode_i;
    item.fwd_present = fwd_present_i;
    item.fwd_signal  = fwd_signal_i;
    item.rev_present = rev_present_i;
    item.rev_signal  = rev_signal_i;
    item.fwd_index   = fwd_win_d;
    item.rev_index   = rev_win_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_win_q <= '0;
      rev_win_q <= '0;
      run_q     <= '0;
    end else if (accept) begin
      fwd_win_q <= fwd_win_d;
      rev_win_q <= rev_win_d;
      run_q     <= run_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_mem_q[q_wptr_q] <= item;
    end
  end

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wptr_q <= 1'b0;
      q_rptr_q <= 1'b0;
      q_cnt_q  <= '0;
    end else begin
      if (accept) begin
        q_wptr_q <= !q_wptr_q;
      end
      if (q_pop_i) begin
        q_rptr_q <= !q_rptr_q;
      end
      q_cnt_q <= q_cnt_q + 2'(accept) - 2'(q_pop_i);
    end
  end

  assign q_valid_o = (q_cnt_q != 2'd0);
  assign q_item_o  = q_mem_q[q_rptr_q];

endmodule

/* rtl/core/ksa_back.sv */
// Back end: clear the table after reset, run the forward then reverse
// read-modify-write of each item and buffer results. Depends on ksa_pkg.
module ksa_back import ksa_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_wdata_i,
  input  logic            q_valid_i,
  input  ksa_item_t       q_item_i,
  output logic            q_pop_o,
  output logic            clear_busy_o,
  output ksa_mem_req_t    mem_req_o,
  input  ksa_entry_t      mem_rdata_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ksa_result_t     result_o
);

  bk_state_e       state_q, state_d;
  logic [IdxW-1:0] clr_addr_q;
  logic [CntW-1:0] max_count_q;
  ksa_item_t       item_q;
  logic            s1_valid_q, s1_rev_q;
  logic            issue_f, issue_r;
  logic [1:0]      resv_q;
  logic            out_pop;

  logic            present;
  logic [SigW-1:0] sig;
  logic            upd_en, upd_sat, upd_we;
  ksa_entry_t      new_entry, upd_val;
  ksa_entry_t      fwd_hold_q;
  logic            fsat_hold_q;
  logic            r_done;
  ksa_result_t     res;

  ksa_result_t     ofifo_q [2];
  logic            ow_q, or_q;
  logic [1:0]      ocnt_q;

  assign out_pop = out_valid_o && out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_CLEAR: if (clr_addr_q == '1) state_d = BK_FWD;
      BK_FWD:   if (issue_f) state_d = BK_REV;
      BK_REV:   state_d = BK_FWD;
      default:  state_d = BK_CLEAR;
    endcase
  end

  // State outputs
  always_comb begin
    clear_busy_o = 1'b0;
    issue_f      = 1'b0;
    issue_r      = 1'b0;
    unique case (state_q)
      BK_CLEAR: clear_busy_o = 1'b1;
      BK_FWD:   issue_f = q_valid_i && ((resv_q < 2'd2) || out_pop);
      BK_REV:   issue_r = 1'b1;
      default:  clear_busy_o = 1'b1;
    endcase
  end

  assign q_pop_o = issue_f;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      clr_addr_q  <= '0;
      max_count_q <= MaxCountReset;
      s1_valid_q  <= 1'b0;
      s1_rev_q    <= 1'b0;
      resv_q      <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_CLEAR) begin
        clr_addr_q <= clr_addr_q + IdxW'(1);
      end
      if (cfg_we_i) begin
        max_count_q <= cfg_wdata_i;
      end
      s1_valid_q <= issue_f || issue_r;
      s1_rev_q   <= issue_r;
      resv_q     <= resv_q + 2'(issue_f) - 2'(out_pop);
    end
  end

  // Hold the item in service
  always_ff @(posedge clk_i) begin
    if (issue_f) begin
      item_q <= q_item_i;
    end
  end

  // Update the entry returned by the table
  always_comb begin
    present         = s1_rev_q ? item_q.rev_present : item_q.fwd_present;
    sig             = s1_rev_q ? item_q.rev_signal : item_q.fwd_signal;
    upd_en          = s1_valid_q && item_q.ready && (item_q.mode == ModeAccum) && present;
    upd_sat         = upd_en && (mem_rdata_i.count >= max_count_q);
    upd_we          = upd_en && !upd_sat;
    new_entry.sum   = mem_rdata_i.sum + SumW'(sig);
    new_entry.count = mem_rdata_i.count + CntW'(1);
    upd_val         = upd_we ? new_entry : mem_rdata_i;
  end

  // Drive the table port
  always_comb begin
    mem_req_o.we    = clear_busy_o || upd_we;
    mem_req_o.waddr = clear_busy_o ? clr_addr_q
                    : (s1_rev_q ? item_q.rev_index : item_q.fwd_index);
    mem_req_o.wdata = clear_busy_o ? '0 : new_entry;
    mem_req_o.raddr = issue_r ? item_q.rev_index : q_item_i.fwd_index;
  end

  // Keep the forward outcome until the reverse one arrives
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && !s1_rev_q) begin
      fwd_hold_q  <= upd_val;
      fsat_hold_q <= upd_sat;
    end
  end

  // Assemble the result; a palindrome reports the entry after both updates
  assign r_done = s1_valid_q && s1_rev_q;
  always_comb begin
    res = '0;
    if (item_q.ready) begin
      res.kmer_ready    = 1'b1;
      res.fwd_index     = item_q.fwd_index;
      res.rev_index     = item_q.rev_index;
      res.fwd_saturated = fsat_hold_q;
      res.rev_saturated = upd_sat;
      res.fwd           = (item_q.fwd_index == item_q.rev_index) ? upd_val : fwd_hold_q;
      res.rev           = upd_val;
    end
  end

  // Result buffer storage
  always_ff @(posedge clk_i) begin
    if (r_done) begin
      ofifo_q[ow_q] <= res;
    end
  end

  // Result buffer pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ow_q   <= 1'b0;
      or_q   <= 1'b0;
      ocnt_q <= '0;
    end else begin
      if (r_done) begin
        ow_q <= !ow_q;
      end
      if (out_pop) begin
        or_q <= !or_q;
      end
      ocnt_q <= ocnt_q + 2'(r_done) - 2'(out_pop);
    end
  end

  assign out_valid_o = (ocnt_q != 2'd0);
  assign result_o    = ofifo_q[or_q];

`ifndef ASSERT_OFF
  a_no_buffer_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_done |-> ((ocnt_q != 2'd2) || out_pop))
    else $error("result buffer overflow");

  a_no_update_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_CLEAR) |-> !upd_we)
    else $error("table update during clearing pass");

  a_rev_follows_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_done |-> $past(s1_valid_q && !s1_rev_q))
    else $error("reverse update without preceding forward update");

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resv_q <= 2'd2)
    else $error("result credit count out of range");
`endif

endmodule

/* rtl/core/kmer_signal_accumulator.sv */
// An accepted item passes the front-end queue, then the forward and the reverse
// read-modify-write on the single write port of the sum/count table, then the result
// buffer; a new item is issued only after the last one's reverse pass and with buffer room.
// Reset: windows, run counter and max_count (100000) reset at once; the table is
// then swept to zero, one entry a cycle, over all 1048576 entries with in_ready_o low.
module kmer_signal_accumulator import ksa_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            mode_i,
  input  logic [7:0]      base_char_i,
  input  logic            fwd_present_i,
  input  logic [SigW-1:0] fwd_signal_i,
  input  logic            rev_present_i,
  input  logic [SigW-1:0] rev_signal_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            kmer_ready_o,
  output logic [IdxW-1:0] fwd_index_o,
  output logic [IdxW-1:0] rev_index_o,
  output logic            fwd_saturated_o,
  output logic            rev_saturated_o,
  output logic [SumW-1:0] fwd_sum_o,
  output logic [CntW-1:0] fwd_count_o,
  output logic [SumW-1:0] rev_sum_o,
  output logic [CntW-1:0] rev_count_o
);

  logic         clear_busy;
  logic         q_valid, q_pop;
  ksa_item_t    q_item;
  ksa_mem_req_t mem_req;
  ksa_entry_t   mem_rdata;
  ksa_result_t  result;

  ksa_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .base_char_i   (base_char_i),
    .fwd_present_i (fwd_present_i),
    .fwd_signal_i  (fwd_signal_i),
    .rev_present_i (rev_present_i),
    .rev_signal_i  (rev_signal_i),
    .clear_busy_i  (clear_busy),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop)
  );

  ksa_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  ksa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .clear_busy_o (clear_busy),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (result)
  );

  // Unpack the result
  assign kmer_ready_o    = result.kmer_ready;
  assign fwd_index_o     = result.fwd_index;
  assign rev_index_o     = result.rev_index;
  assign fwd_saturated_o = result.fwd_saturated;
  assign rev_saturated_o = result.rev_saturated;
  assign fwd_sum_o       = result.fwd.sum;
  assign fwd_count_o     = result.fwd.count;
  assign rev_sum_o       = result.rev.sum;
  assign rev_count_o     = result.rev.count;

endmodule
